/* sv/pcbs_pkg.sv */
// Package for the pseudocost branch selector: widths, request codes, shared types.
// No dependencies.
`timescale 1ns / 1ps
package pcbs_pkg;
  localparam int NumVars = 1024;
  localparam int IdxW = 10;
  localparam int CntMax = 65535;

  typedef enum logic [1:0] {
    REQ_RECORD = 2'd0,
    REQ_SCORE  = 2'd1,
    REQ_LOAD   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  localparam logic CFG_WMIN = 1'b0;
  localparam logic CFG_WMAX = 1'b1;

  typedef struct packed {
    req_e              req;
    logic [IdxW-1:0]   idx;
    logic              dir;
    logic [15:0]       frac;
    logic signed [31:0] amt;
    logic              last;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_RDWAIT, ST_DIV1, ST_DIV2, ST_WRITE,
    ST_MUL1, ST_MUL2, ST_SCORE, ST_PICK, ST_EMIT
  } st_e;
endpackage

/* sv/pcbs_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module pcbs_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* sv/pcbs_divider.sv */
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
// Depends on pcbs_pkg.
`timescale 1ns / 1ps
module pcbs_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic [31:0]        den_i,
  output logic               done_o,
  output logic signed [63:0] quo_o
);
  import pcbs_pkg::*;
  logic [63:0] rem_q, rem_d, quo_q, quo_d;
  logic [31:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d;
  logic [64:0] trial;
  logic [63:0] step_quo;

  // done and the quotient come from the current step only, so a new start
  // in the finishing cycle does not disturb them
  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q;
    neg_d = neg_q; busy_d = busy_q;
    trial = {rem_q, quo_q[63]} - {33'd0, den_q};
    step_quo = {quo_q[62:0], ~trial[64]};
    if (start_i) begin
      neg_d = num_i[63];
      quo_d = num_i[63] ? 64'(-num_i) : 64'(num_i);
      rem_d = '0; den_d = den_i; cnt_d = 7'd64; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) rem_d = trial[63:0];
      else rem_d = {rem_q[62:0], quo_q[63]};
      quo_d = step_quo;
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end
  assign done_o = busy_q && (cnt_q == 7'd1);
  assign quo_o  = neg_q ? -$signed(step_quo) : $signed(step_quo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end
endmodule

/* sv/pcbs_front.sv */
// Front end: accepts items, drops items with the REQ_NONE code,
// and queues commands in a two-entry FIFO. Depends on pcbs_pkg.
`timescale 1ns / 1ps
module pcbs_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  pcbs_pkg::cmd_t         cmd_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_pop_i,
  output pcbs_pkg::cmd_t         cmd_o
);
  import pcbs_pkg::*;
  cmd_t       fifo_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q, push, keep;

  // Index is full width of the table, so every index is in range.
  assign keep       = (cmd_i.req != REQ_NONE);
  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rp_q];
  always_comb cnt_d = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i && cmd_valid_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (cmd_pop_i && cmd_valid_o) rp_q <= ~rp_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= cmd_i;
  end
endmodule

/* sv/pcbs_back.sv */
// Back end: pseudocost tables, record averaging via a shared divider,
// candidate scoring and best tracking. Depends on pcbs_pkg, pcbs_ram, pcbs_divider.
`timescale 1ns / 1ps
module pcbs_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_pop_o,
  input  pcbs_pkg::cmd_t                cmd_i,
  input  logic [15:0]                   wmin_i,
  input  logic [15:0]                   wmax_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pcbs_pkg::IdxW-1:0]     best_index_o,
  output logic signed [31:0]            down_estimate_o,
  output logic signed [31:0]            up_estimate_o
);
  import pcbs_pkg::*;
  st_e  st_q, st_d;
  cmd_t c_q;
  logic [31:0] ucost, dcost;
  logic [15:0] ucnt, dcnt;
  logic we_uc, we_dc, we_un, we_dn;
  logic [31:0] wc;
  logic [15:0] wn;
  logic [31:0] cost_q, cost_d;
  logic [15:0] n_q;
  logic signed [63:0] acc_q, acc_d;
  logic signed [63:0] num;
  logic [31:0] den;
  logic div_start, div_done;
  logic signed [63:0] quo;
  logic signed [63:0] dn_q, up_q, lo_q, hi_q, s_q;
  logic signed [63:0] best_s_q;
  logic [IdxW-1:0] best_i_q;
  logic signed [31:0] best_dn_q, best_up_q;
  logic started_q, ov_q;
  logic [16:0] omf;
  logic skip;

  pcbs_ram #(.Width(32), .Depth(NumVars)) u_ucost (.clk_i, .we_i(we_uc),
    .addr_i(c_q.idx), .wdata_i(wc), .rdata_o(ucost));
  pcbs_ram #(.Width(32), .Depth(NumVars)) u_dcost (.clk_i, .we_i(we_dc),
    .addr_i(c_q.idx), .wdata_i(wc), .rdata_o(dcost));
  pcbs_ram #(.Width(16), .Depth(NumVars)) u_ucnt (.clk_i, .we_i(we_un),
    .addr_i(c_q.idx), .wdata_i(wn), .rdata_o(ucnt));
  pcbs_ram #(.Width(16), .Depth(NumVars)) u_dcnt (.clk_i, .we_i(we_dn),
    .addr_i(c_q.idx), .wdata_i(wn), .rdata_o(dcnt));

  pcbs_divider u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(num),
    .den_i(den), .done_o(div_done), .quo_o(quo));

  assign omf  = 17'd65536 - {1'b0, c_q.frac};
  assign skip = c_q.dir && (c_q.frac == 16'd0);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:   if (cmd_valid_i) st_d = ST_READ;
      ST_READ: begin
        if (c_q.req == REQ_LOAD) st_d = ST_IDLE;
        else st_d = ST_RDWAIT;
      end
      ST_RDWAIT: begin
        if (c_q.req == REQ_SCORE) st_d = ST_MUL1;
        else if (skip) st_d = ST_IDLE;
        else st_d = ST_DIV1;
      end
      ST_DIV1:  if (div_done) st_d = ST_DIV2;
      ST_DIV2:  if (div_done) st_d = ST_WRITE;
      ST_WRITE: st_d = ST_IDLE;
      ST_MUL1:  st_d = ST_MUL2;
      ST_MUL2:  st_d = ST_SCORE;
      ST_SCORE: st_d = ST_PICK;
      ST_PICK:  st_d = c_q.last ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (!ov_q || !out_stall_i) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  // outputs / datapath
  always_comb begin
    cmd_pop_o = 1'b0; we_uc = 1'b0; we_dc = 1'b0; we_un = 1'b0; we_dn = 1'b0;
    wc = c_q.amt; wn = '0; div_start = 1'b0;
    cost_d = cost_q; acc_d = acc_q;
    num = '0; den = '0;
    unique case (st_q)
      ST_IDLE: cmd_pop_o = cmd_valid_i;
      ST_READ: if (c_q.req == REQ_LOAD) begin
        we_uc = 1'b1; we_dc = 1'b1; we_un = 1'b1; we_dn = 1'b1;
      end
      ST_RDWAIT: begin
        cost_d = c_q.dir ? ucost : dcost;
        num = 64'(c_q.amt) <<< 16;
        den = c_q.dir ? {16'd0, c_q.frac} : {15'd0, omf};
        div_start = (c_q.req == REQ_RECORD) && !skip;
      end
      ST_DIV1: if (div_done) begin
        acc_d = $signed({48'd0, n_q}) * $signed(64'(signed'(cost_q))) + quo;
        num = acc_d;
        den = {16'd0, n_q} + 32'd1;
        div_start = 1'b1;
      end
      ST_DIV2: if (div_done) cost_d = sat32(quo);
      ST_WRITE: begin
        wc = cost_q;
        wn = (n_q == 16'(CntMax)) ? n_q : n_q + 16'd1;
        we_uc = c_q.dir; we_un = c_q.dir;
        we_dc = !c_q.dir; we_dn = !c_q.dir;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; started_q <= 1'b0; ov_q <= 1'b0;
      best_s_q <= '0; best_i_q <= '0; best_dn_q <= '0; best_up_q <= '0;
      best_index_o <= '0; down_estimate_o <= '0; up_estimate_o <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_PICK) begin
        if (!started_q || s_q > best_s_q) begin
          best_s_q <= s_q; best_i_q <= c_q.idx;
          best_dn_q <= sat32(dn_q); best_up_q <= sat32(up_q);
        end
        started_q <= !c_q.last;
      end
      if (st_q == ST_EMIT && (!ov_q || !out_stall_i)) begin
        ov_q <= 1'b1;
        best_index_o <= best_i_q;
        down_estimate_o <= best_dn_q;
        up_estimate_o <= best_up_q;
      end else if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) c_q <= cmd_i;
    cost_q <= cost_d;
    acc_q <= acc_d;
    if (st_q == ST_RDWAIT) n_q <= c_q.dir ? ucnt : dcnt;
    if (st_q == ST_MUL1) begin
      dn_q <= ($signed(64'(signed'(dcost))) * $signed({48'd0, c_q.frac})) >>> 16;
      up_q <= ($signed(64'(signed'(ucost))) * $signed({47'd0, omf})) >>> 16;
    end
    if (st_q == ST_MUL2) begin
      lo_q <= (dn_q < up_q) ? dn_q : up_q;
      hi_q <= (dn_q > up_q) ? dn_q : up_q;
    end
    if (st_q == ST_SCORE)
      s_q <= $signed({48'd0, wmin_i}) * lo_q + $signed({48'd0, wmax_i}) * hi_q;
  end

  assign out_valid_o = ov_q;
endmodule

/* sv/pseudocost_branch_selector.sv */
// Top level of the pseudocost branch selector: config registers, front, back.
// Depends on pcbs_pkg, pcbs_front, pcbs_back.
`timescale 1ns / 1ps
// Items are processed one at a time by the back end behind a two-entry queue.
// In the back end a load item writes all four tables; a score item is read,
// multiplied, ordered, scored and picked, and emits the winner when it ends the
// run; a record item runs two 64-step divisions (by the fraction, or by 65536
// minus it when down, then by count+1) back to back through one bit-serial
// divider. A stalled result holds the back end in its emit state. Table entries
// start undefined; load a variable before recording or scoring it.
module pseudocost_branch_selector (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [9:0]         var_index_i,
  input  logic               direction_i,
  input  logic [15:0]        frac_part_i,
  input  logic signed [31:0] amount_i,
  input  logic               last_candidate_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [9:0]         best_index_o,
  output logic signed [31:0] down_estimate_o,
  output logic signed [31:0] up_estimate_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import pcbs_pkg::*;
  cmd_t cmd_in, cmd;
  logic cmd_valid, cmd_pop;
  logic [15:0] wmin_q, wmax_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wmin_q <= 16'd256; wmax_q <= 16'd0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_WMIN) wmin_q <= cfg_data_i;
      else wmax_q <= cfg_data_i;
    end
  end

  always_comb begin
    cmd_in.req  = req_e'(req_type_i);
    cmd_in.idx  = var_index_i;
    cmd_in.dir  = direction_i;
    cmd_in.frac = frac_part_i;
    cmd_in.amt  = amount_i;
    cmd_in.last = last_candidate_i;
  end

  pcbs_front u_front (.clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i(cmd_in),
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd));

  pcbs_back u_back (.clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop),
    .cmd_i(cmd), .wmin_i(wmin_q), .wmax_i(wmax_q), .out_valid_o, .out_stall_i,
    .best_index_o, .down_estimate_o, .up_estimate_o);

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(best_index_o))
    else $error("result changed while stalled");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("pop from empty queue");
`endif
endmodule

/* tb/pseudocost_branch_selector_checker.sv */
// Checker for the pseudocost branch selector: watches the input, result and config
// transfers, keeps its own pseudocost table and compares each winner. Depends on pcbs_pkg.
`timescale 1ns / 1ps
module pseudocost_branch_selector_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         req_type_i,
  input  logic [9:0]         var_index_i,
  input  logic               direction_i,
  input  logic [15:0]        frac_part_i,
  input  logic signed [31:0] amount_i,
  input  logic               last_candidate_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [9:0]         best_index_i,
  input  logic signed [31:0] down_estimate_i,
  input  logic signed [31:0] up_estimate_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import pcbs_pkg::*;

  typedef struct packed {
    logic [9:0]         idx;
    logic signed [31:0] dn;
    logic signed [31:0] up;
  } winner_t;

  logic signed [31:0] cost_up [NumVars];
  logic signed [31:0] cost_dn [NumVars];
  logic [15:0]        cnt_up [NumVars];
  logic [15:0]        cnt_dn [NumVars];
  logic [15:0]        w_min, w_max;
  longint             best_score;
  winner_t            best;
  logic               started;
  winner_t            winners_q[$];

  assign pending_o = winners_q.size();

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint floor16(longint p);
    longint q;
    q = p / 65536;
    if ((p % 65536) != 0 && p < 0) q--;
    return q;
  endfunction

  task automatic fold_cost(inout logic signed [31:0] cost, inout logic [15:0] cnt,
                           input logic signed [31:0] amt, input longint dv);
    longint c, n;
    if (dv == 0) return;
    c = (longint'(amt) * 65536) / dv;
    n = cnt;
    cost = sat32((n * longint'(cost) + c) / (n + 1));
    if (cnt != 16'(CntMax)) cnt = cnt + 16'd1;
  endtask

  task automatic apply_item();
    longint cd, cu, dn, up, lo, hi, s, f;
    logic [9:0] i;
    i = var_index_i;
    f = frac_part_i;
    case (req_e'(req_type_i))
      REQ_LOAD: begin
        cost_up[i] = amount_i;
        cost_dn[i] = amount_i;
        cnt_up[i] = '0;
        cnt_dn[i] = '0;
      end
      REQ_RECORD: begin
        if (direction_i) fold_cost(cost_up[i], cnt_up[i], amount_i, f);
        else fold_cost(cost_dn[i], cnt_dn[i], amount_i, 65536 - f);
      end
      REQ_SCORE: begin
        cd = cost_dn[i];
        cu = cost_up[i];
        dn = floor16(cd * f);
        up = floor16(cu * (65536 - f));
        lo = dn < up ? dn : up;
        hi = dn > up ? dn : up;
        s = longint'(w_min) * lo + longint'(w_max) * hi;
        if (!started || s > best_score) begin
          best_score = s;
          best = '{i, sat32(dn), sat32(up)};
          started = 1'b1;
        end
        if (last_candidate_i) begin
          winners_q.push_back(best);
          started = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    winner_t w;
    if (!rst_ni) begin
      w_min <= 16'd256;
      w_max <= 16'd0;
      started = 1'b0;
      best_score = 0;
      best = '0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_WMIN) w_min <= cfg_data_i;
        else w_max <= cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) apply_item();
      if (out_valid_i && !out_stall_i) begin
        if (winners_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result idx=%0d", best_index_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          w = winners_q.pop_front();
          if (w.idx !== best_index_i || w.dn !== down_estimate_i ||
              w.up !== up_estimate_i) begin
            if (fail_count_o < 10)
              $display("mismatch: exp idx=%0d dn=%0d up=%0d got idx=%0d dn=%0d up=%0d",
                       w.idx, w.dn, w.up, best_index_i, down_estimate_i, up_estimate_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

/* tb/pseudocost_branch_selector_tb.sv */
// Testbench top for the pseudocost branch selector: clock, reset, stimulus, verdict.
// Depends on pcbs_pkg, pseudocost_branch_selector, pseudocost_branch_selector_checker.
`timescale 1ns / 1ps
module pseudocost_branch_selector_tb;
  import pcbs_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         req_type_i = '0;
  logic [9:0]         var_index_i = '0;
  logic               direction_i = 1'b0;
  logic [15:0]        frac_part_i = '0;
  logic signed [31:0] amount_i = '0;
  logic               last_candidate_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [9:0]         best_index_o;
  logic signed [31:0] down_estimate_o, up_estimate_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = 1'b0;
  logic [15:0]        cfg_data_i = '0;
  int                 fail_count, pending;
  logic               hold_off = 1'b0;
  logic               loaded [NumVars];

  always #10 clk_i = ~clk_i;

  pseudocost_branch_selector DUT (.*);

  pseudocost_branch_selector_checker u_checker (
    .in_stall_i(in_stall_o), .out_valid_i(out_valid_o), .best_index_i(best_index_o),
    .down_estimate_i(down_estimate_o), .up_estimate_i(up_estimate_o),
    .cfg_ready_i(cfg_ready_o), .fail_count_o(fail_count), .pending_o(pending), .*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] rand_amt();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_frac();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver stalls; a long hold-off pins stall high
  initial begin
    int g;
    forever begin
      @(posedge clk_i);
      if (hold_off) out_stall_i <= 1'b1;
      else begin
        g = gap_len();
        out_stall_i <= (g != 0);
        repeat (g) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send(input req_e r, input logic [9:0] i, input logic d,
                      input logic [15:0] f, input logic [31:0] a, input logic l);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= r;
    var_index_i <= i;
    direction_i <= d;
    frac_part_i <= f;
    amount_i <= a;
    last_candidate_i <= l;
    if (r == REQ_LOAD) loaded[i] = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // results drained, then room for queued record items to finish
  task automatic idle_and_drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [9:0] pick_loaded(input int hi);
    logic [9:0] i;
    do i = 10'($urandom_range(0, hi)); while (!loaded[i]);
    return i;
  endfunction

  task automatic random_phase(input int n, input int hi);
    int k, len;
    logic [9:0] i;
    k = 0;
    while (k < n) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          send(REQ_LOAD, 10'($urandom_range(0, hi)), 1'($urandom), 16'($urandom),
               rand_amt(), 1'($urandom));
          k++;
        end
        2, 3, 4: begin
          i = pick_loaded(hi);
          send(REQ_RECORD, i, 1'($urandom), rand_frac(), rand_amt(), 1'($urandom));
          k++;
        end
        5: begin
          send(REQ_NONE, 10'($urandom), 1'($urandom), 16'($urandom), $urandom,
               1'($urandom));
          k++;
        end
        default: begin
          len = $urandom_range(1, 6);
          for (int c = 0; c < len; c++) begin
            i = pick_loaded(hi);
            send(REQ_SCORE, i, 1'($urandom), rand_frac(), $urandom, c == len - 1);
            k++;
          end
        end
      endcase
    end
  endtask

  initial begin
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, each request, zero divisors, ties, single-candidate runs
    send(REQ_LOAD, 10'd0, 1'b0, 16'h0, 32'h7fffffff, 1'b0);
    send(REQ_LOAD, 10'd1023, 1'b1, 16'hffff, 32'h80000000, 1'b1);
    send(REQ_LOAD, 10'd5, 1'b0, 16'h0, 32'h00010000, 1'b0);
    send(REQ_LOAD, 10'd6, 1'b0, 16'h0, 32'h00010000, 1'b0);
    send(REQ_RECORD, 10'd5, 1'b1, 16'h0, 32'h00050000, 1'b0);
    send(REQ_RECORD, 10'd5, 1'b1, 16'hffff, 32'h80000000, 1'b1);
    send(REQ_RECORD, 10'd5, 1'b0, 16'h0, 32'h7fffffff, 1'b0);
    send(REQ_RECORD, 10'd0, 1'b0, 16'hffff, 32'h7fffffff, 1'b0);
    send(REQ_RECORD, 10'd1023, 1'b1, 16'h0001, 32'h80000000, 1'b0);
    send(REQ_NONE, 10'd3, 1'b1, 16'hffff, 32'hffffffff, 1'b1);
    send(REQ_SCORE, 10'd0, 1'b0, 16'hffff, 32'h0, 1'b1);
    send(REQ_SCORE, 10'd6, 1'b1, 16'h8000, 32'h0, 1'b0);
    send(REQ_SCORE, 10'd6, 1'b0, 16'h8000, 32'h0, 1'b0);
    send(REQ_SCORE, 10'd1023, 1'b0, 16'h0, 32'h0, 1'b0);
    send(REQ_SCORE, 10'd5, 1'b0, 16'h0, 32'h0, 1'b1);
    send(REQ_SCORE, 10'd1023, 1'b0, 16'hffff, 32'h0, 1'b1);
    idle_and_drain();

    write_cfg(CFG_WMIN, 16'hffff);
    write_cfg(CFG_WMAX, 16'hffff);
    send(REQ_SCORE, 10'd0, 1'b0, 16'h0, 32'h0, 1'b0);
    send(REQ_SCORE, 10'd1023, 1'b0, 16'h8000, 32'h0, 1'b1);
    idle_and_drain();

    // receiver holds off while the sender keeps offering
    hold_off = 1'b1;
    fork
      random_phase(120, 15);
      begin
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    idle_and_drain();

    write_cfg(CFG_WMIN, 16'h0000);
    write_cfg(CFG_WMAX, 16'h0100);
    random_phase(400, 63);
    idle_and_drain();
    write_cfg(CFG_WMIN, 16'h0000);
    write_cfg(CFG_WMAX, 16'h0000);
    random_phase(150, 7);
    idle_and_drain();
    write_cfg(CFG_WMIN, 16'($urandom));
    write_cfg(CFG_WMAX, 16'($urandom));
    random_phase(500, 1023);
    idle_and_drain();
    write_cfg(CFG_WMIN, 16'h0100);
    write_cfg(CFG_WMAX, 16'($urandom));
    random_phase(450, 31);
    idle_and_drain();

    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #(20 * 1000000);
    $display("Simulation FAILED");
    $finish;
  end
endmodule

/* filelist.f */
sv/pcbs_pkg.sv
sv/pcbs_ram.sv
sv/pcbs_divider.sv
sv/pcbs_front.sv
sv/pcbs_back.sv
sv/pseudocost_branch_selector.sv
tb/pseudocost_branch_selector_checker.sv
tb/pseudocost_branch_selector_tb.sv
